// ===== hdl/pwmfd_pkg.sv =====
// -----------------------------------------------------------------------------
// pwmfd_pkg: shared constants for the PWM duty fader
// Field widths, parameter defaults and request codes used by the interfaces
// and the top level.
// -----------------------------------------------------------------------------
package pwmfd_pkg;

   localparam int NUM_BANKS_DEF         = 2;
   localparam int CHANNELS_PER_BANK_DEF = 8;
   localparam int DUTY_BITS_DEF         = 16;

   localparam int BANK_FIELD_W = 1;
   localparam int CHAN_FIELD_W = 3;
   localparam int DUTY_FIELD_W = 16;
   localparam int LEN_W        = 24;
   localparam int ELAPSED_W    = 25;
   localparam int STEP_W       = 10;

   localparam logic [STEP_W-1:0]    STEP_RESET  = 10'd50;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

   // request codes
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

endpackage

// ===== hdl/pwmfd_req_if.sv =====
// -----------------------------------------------------------------------------
// pwmfd_req_if: request channel of the PWM duty fader
// Valid/ready channel carrying fade starts and time ticks.
// -----------------------------------------------------------------------------
interface pwmfd_req_if
   import pwmfd_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic                    req_type;
   logic [BANK_FIELD_W-1:0] bank;
   logic [CHAN_FIELD_W-1:0] channel_index;
   logic [DUTY_FIELD_W-1:0] goal_duty;
   logic [LEN_W-1:0]        fade_ms;

   modport source (output valid, req_type, bank, channel_index, goal_duty, fade_ms,
                   input ready);
   modport sink   (input valid, req_type, bank, channel_index, goal_duty, fade_ms,
                   output ready);
endinterface

// ===== hdl/pwmfd_rsp_if.sv =====
// -----------------------------------------------------------------------------
// pwmfd_rsp_if: duty update channel of the PWM duty fader
// Valid/ready channel carrying one changed channel duty per transfer.
// -----------------------------------------------------------------------------
interface pwmfd_rsp_if
   import pwmfd_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [BANK_FIELD_W-1:0] out_bank;
   logic [CHAN_FIELD_W-1:0] out_channel;
   logic [DUTY_FIELD_W-1:0] new_duty;
   logic                    last;

   modport source (output valid, out_bank, out_channel, new_duty, last, input ready);
   modport sink   (input valid, out_bank, out_channel, new_duty, last, output ready);
endinterface

// ===== hdl/pwmfd_ram.sv =====
// -----------------------------------------------------------------------------
// pwmfd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// -----------------------------------------------------------------------------
module pwmfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/pwmfd_div.sv =====
// -----------------------------------------------------------------------------
// pwmfd_div: restoring divider, one quotient bit per cycle
// Divides a QW+DW bit dividend by a DW bit divisor whose quotient is known
// to fit in QW bits. Done pulses with the quotient valid.
// -----------------------------------------------------------------------------
module pwmfd_div #(
   parameter int QW = 16,
   parameter int DW = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DW+QW-1:0] dividend,
   input  logic [DW-1:0]    divisor,
   output logic             done,
   output logic [QW-1:0]    quotient
);

   localparam int CNT_W = $clog2(QW + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [QW-1:0]    lo_ff, lo_in;
   logic [DW-1:0]    dvs_ff, dvs_in;
   logic [DW:0]      trial;
   logic [DW:0]      diff;

   always_comb begin
      trial   = {rem_ff, lo_ff[QW-1]};
      diff    = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QW);
         rem_in  = dividend[DW+QW-1:QW];
         lo_in   = dividend[QW-1:0];
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DW-1:0];
            lo_in  = {lo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            lo_in  = {lo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = lo_ff;

   a_busy_cnt : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with no steps left");

   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < dvs_ff)
      else $error("partial remainder not below divisor");

endmodule

// ===== hdl/multi_channel_pwm_duty_fader.sv =====
// -----------------------------------------------------------------------------
// multi_channel_pwm_duty_fader: linear duty fade over a table of PWM channels
// A start reads the channel record, then writes it back. A tick scans the
// channels in turn: an idle channel is skipped, an armed channel that finishes
// is read, loaded and written back, and one still ramping also goes through the
// multiply and the shared serial divider; a flush step ends the scan and sends
// the final update. Output back-pressure can stall a tick. One request at a time.
// Reset clears the armed and written bits at once; no clearing pass is needed.
// -----------------------------------------------------------------------------
module multi_channel_pwm_duty_fader
   import pwmfd_pkg::*;
#(
   parameter int NUM_BANKS         = NUM_BANKS_DEF,
   parameter int CHANNELS_PER_BANK = CHANNELS_PER_BANK_DEF,
   parameter int DUTY_BITS         = DUTY_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   pwmfd_req_if.sink         req_chan,
   pwmfd_rsp_if.source       rsp_chan,
   input  logic              csr_wr_en,
   input  logic [STEP_W-1:0] csr_wr_data
);

   localparam int NUM_CH    = NUM_BANKS * CHANNELS_PER_BANK;
   localparam int IDX_W     = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
   localparam int IDX_CNT_W = $clog2(NUM_CH + 1);
   localparam int BANK_W    = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
   localparam int CH_W      = (CHANNELS_PER_BANK > 1) ? $clog2(CHANNELS_PER_BANK) : 1;
   localparam int PROD_W    = LEN_W + DUTY_BITS;

   // sequencer codes
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_ST_WR   = 4'd1;
   localparam logic [3:0] S_TK_SCAN = 4'd2;
   localparam logic [3:0] S_TK_LOAD = 4'd3;
   localparam logic [3:0] S_TK_MUL  = 4'd4;
   localparam logic [3:0] S_TK_DGO  = 4'd5;
   localparam logic [3:0] S_TK_DIV  = 4'd6;
   localparam logic [3:0] S_TK_WR   = 4'd7;
   localparam logic [3:0] S_TK_FLSH = 4'd8;

   // one channel record as held in the table RAM
   typedef struct packed {
      logic [DUTY_BITS-1:0] present;
      logic [DUTY_BITS-1:0] start;
      logic [DUTY_BITS-1:0] target;
      logic [LEN_W-1:0]     len;
      logic [ELAPSED_W-1:0] elapsed;
   } chan_rec_type;

   localparam int REC_W = $bits(chan_rec_type);

   // control state
   logic [3:0]           state_ff, state_in;
   logic [IDX_CNT_W-1:0] idx_ff, idx_in;
   logic [BANK_W-1:0]    bank_ff, bank_in;
   logic [CH_W-1:0]      chan_ff, chan_in;
   logic [NUM_CH-1:0]    armed_ff, armed_in;
   logic [NUM_CH-1:0]    vld_ff, vld_in;      // record was ever written
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload / datapath
   logic [IDX_W-1:0]        st_idx_ff, st_idx_in;
   logic [DUTY_BITS-1:0]    st_goal_ff, st_goal_in;
   logic [LEN_W-1:0]        st_len_ff, st_len_in;
   chan_rec_type            rec_ff, rec_in;
   logic [DUTY_BITS-1:0]    v_ff, v_in;
   logic                    fin_ff, fin_in;
   logic                    dir_ff, dir_in;    // 1: ramp down
   logic [DUTY_BITS-1:0]    diff_ff, diff_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [BANK_FIELD_W-1:0] pend_bank_ff, pend_bank_in;
   logic [CHAN_FIELD_W-1:0] pend_chan_ff, pend_chan_in;
   logic [DUTY_FIELD_W-1:0] pend_duty_ff, pend_duty_in;
   logic [BANK_FIELD_W-1:0] rsp_bank_ff, rsp_bank_in;
   logic [CHAN_FIELD_W-1:0] rsp_chan_ff, rsp_chan_in;
   logic [DUTY_FIELD_W-1:0] rsp_duty_ff, rsp_duty_in;
   logic                    rsp_last_ff, rsp_last_in;

   // RAM and divider hookup
   logic             ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [REC_W-1:0] ram_wr_data, ram_rd_data;
   chan_rec_type     rd_rec, wr_rec;
   logic             div_start, div_done;
   logic [DUTY_BITS-1:0] div_q;

   // helpers
   logic [IDX_W-1:0]     cur_idx;
   logic                 st_in_range;
   logic [IDX_W-1:0]     st_addr;
   logic                 out_free;
   logic                 changed;
   logic [ELAPSED_W:0]   el_sum;
   logic [ELAPSED_W-1:0] el_sat;
   logic [DUTY_BITS-1:0] ld_present;
   logic                 ld_fin;

   pwmfd_ram #(
      .WIDTH (REC_W),
      .DEPTH (NUM_CH),
      .ADDR_W(IDX_W)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   pwmfd_div #(
      .QW(DUTY_BITS),
      .DW(LEN_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(prod_ff),
      .divisor (rec_ff.len),
      .done    (div_done),
      .quotient(div_q)
   );

   assign cur_idx     = idx_ff[IDX_W-1:0];
   assign rd_rec      = chan_rec_type'(ram_rd_data);
   assign ram_wr_data = REC_W'(wr_rec);
   assign st_in_range = (int'(req_chan.bank) < NUM_BANKS) &&
                        (int'(req_chan.channel_index) < CHANNELS_PER_BANK);
   assign st_addr     = IDX_W'(int'(req_chan.bank) * CHANNELS_PER_BANK +
                               int'(req_chan.channel_index));
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign changed     = (v_ff != rec_ff.present);

   // elapsed advance, saturating at the field maximum
   assign el_sum = {1'b0, rec_ff.elapsed} + (ELAPSED_W + 1)'(step_ff);
   assign el_sat = el_sum[ELAPSED_W] ? ELAPSED_MAX : el_sum[ELAPSED_W-1:0];

   // a never-written record reads as all zero duty
   assign ld_present = vld_ff[cur_idx] ? rd_rec.present : '0;
   assign ld_fin     = (rd_rec.len == '0) ||
                       (rd_rec.elapsed >= {1'b0, rd_rec.len}) ||
                       (rd_rec.start == rd_rec.target);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      bank_in       = bank_ff;
      chan_in       = chan_ff;
      armed_in      = armed_ff;
      vld_in        = vld_ff;
      step_in       = step_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      st_idx_in     = st_idx_ff;
      st_goal_in    = st_goal_ff;
      st_len_in     = st_len_ff;
      rec_in        = rec_ff;
      v_in          = v_ff;
      fin_in        = fin_ff;
      dir_in        = dir_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      pend_bank_in  = pend_bank_ff;
      pend_chan_in  = pend_chan_ff;
      pend_duty_in  = pend_duty_ff;
      rsp_bank_in   = rsp_bank_ff;
      rsp_chan_in   = rsp_chan_ff;
      rsp_duty_in   = rsp_duty_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cur_idx;
      wr_rec        = rec_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = cur_idx;
      div_start     = 1'b0;

      // drop the output register once its transfer completes
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         step_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.req_type == REQ_TICK) begin
                  idx_in   = '0;
                  bank_in  = '0;
                  chan_in  = '0;
                  state_in = S_TK_SCAN;
               end else if (st_in_range) begin
                  // fetch the record so the start duty can copy the present duty
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = st_addr;
                  st_idx_in   = st_addr;
                  st_goal_in  = DUTY_BITS'(req_chan.goal_duty);
                  st_len_in   = req_chan.fade_ms;
                  state_in    = S_ST_WR;
               end
            end
         end

         S_ST_WR: begin
            wr_rec.present = vld_ff[st_idx_ff] ? rd_rec.present : '0;
            wr_rec.start   = wr_rec.present;
            wr_rec.target  = st_goal_ff;
            wr_rec.len     = st_len_ff;
            wr_rec.elapsed = '0;
            ram_wr_en      = 1'b1;
            ram_wr_addr    = st_idx_ff;
            armed_in[st_idx_ff] = 1'b1;
            vld_in[st_idx_ff]   = 1'b1;
            state_in       = S_IDLE;
         end

         S_TK_SCAN: begin
            if (idx_ff == IDX_CNT_W'(NUM_CH)) begin
               state_in = S_TK_FLSH;
            end else if (armed_ff[cur_idx]) begin
               ram_rd_en = 1'b1;
               state_in  = S_TK_LOAD;
            end else begin
               // skip an idle channel
               idx_in = idx_ff + IDX_CNT_W'(1);
               if (chan_ff == CH_W'(CHANNELS_PER_BANK - 1)) begin
                  chan_in = '0;
                  bank_in = bank_ff + BANK_W'(1);
               end else begin
                  chan_in = chan_ff + CH_W'(1);
               end
            end
         end

         S_TK_LOAD: begin
            rec_in         = rd_rec;
            rec_in.present = ld_present;
            fin_in         = ld_fin;
            dir_in         = rd_rec.start > rd_rec.target;
            diff_in        = (rd_rec.start > rd_rec.target) ?
                             rd_rec.start - rd_rec.target :
                             rd_rec.target - rd_rec.start;
            if (ld_fin) begin
               v_in     = rd_rec.target;
               state_in = S_TK_WR;
            end else begin
               state_in = S_TK_MUL;
            end
         end

         S_TK_MUL: begin
            // elapsed is below the length here, so its low bits carry it all
            prod_in  = PROD_W'(rec_ff.elapsed[LEN_W-1:0]) * PROD_W'(diff_ff);
            state_in = S_TK_DGO;
         end

         S_TK_DGO: begin
            div_start = 1'b1;
            state_in  = S_TK_DIV;
         end

         S_TK_DIV: begin
            if (div_done) begin
               v_in     = dir_ff ? rec_ff.start - div_q : rec_ff.start + div_q;
               state_in = S_TK_WR;
            end
         end

         S_TK_WR: begin
            // hold while a new update would need a busy output register
            if (!(changed && pend_valid_ff && !out_free)) begin
               if (changed) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_bank_in  = pend_bank_ff;
                     rsp_chan_in  = pend_chan_ff;
                     rsp_duty_in  = pend_duty_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_bank_in  = bank_ff[0];
                  pend_chan_in  = CHAN_FIELD_W'(chan_ff);
                  pend_duty_in  = DUTY_FIELD_W'(v_ff);
               end
               wr_rec.present = v_ff;
               wr_rec.elapsed = el_sat;
               ram_wr_en      = 1'b1;
               vld_in[cur_idx] = 1'b1;
               if (fin_ff) begin
                  armed_in[cur_idx] = 1'b0;
               end
               idx_in = idx_ff + IDX_CNT_W'(1);
               if (chan_ff == CH_W'(CHANNELS_PER_BANK - 1)) begin
                  chan_in = '0;
                  bank_in = bank_ff + BANK_W'(1);
               end else begin
                  chan_in = chan_ff + CH_W'(1);
               end
               state_in = S_TK_SCAN;
            end
         end

         S_TK_FLSH: begin
            // the held update is the final one of this tick
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_bank_in   = pend_bank_ff;
               rsp_chan_in   = pend_chan_ff;
               rsp_duty_in   = pend_duty_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         bank_ff       <= '0;
         chan_ff       <= '0;
         armed_ff      <= '0;
         vld_ff        <= '0;
         step_ff       <= STEP_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         bank_ff       <= bank_in;
         chan_ff       <= chan_in;
         armed_ff      <= armed_in;
         vld_ff        <= vld_in;
         step_ff       <= step_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      st_idx_ff    <= st_idx_in;
      st_goal_ff   <= st_goal_in;
      st_len_ff    <= st_len_in;
      rec_ff       <= rec_in;
      v_ff         <= v_in;
      fin_ff       <= fin_in;
      dir_ff       <= dir_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      pend_bank_ff <= pend_bank_in;
      pend_chan_ff <= pend_chan_in;
      pend_duty_ff <= pend_duty_in;
      rsp_bank_ff  <= rsp_bank_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_duty_ff  <= rsp_duty_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // the request side takes a transfer only between requests
   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_bank    = rsp_bank_ff;
   assign rsp_chan.out_channel = rsp_chan_ff;
   assign rsp_chan.new_duty    = rsp_duty_ff;
   assign rsp_chan.last        = rsp_last_ff;

   a_idle_no_pending : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pend_valid_ff)
      else $error("held duty update left behind after a tick");

   a_write_armed : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TK_WR |-> armed_ff[cur_idx])
      else $error("tick write-back on a disarmed channel");

   a_div_fits : assert property (@(posedge clock) disable iff (reset)
      div_start |-> prod_ff[PROD_W-1:DUTY_BITS] < rec_ff.len)
      else $error("ramp quotient would overflow the duty width");

   a_rsp_last_flush : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !rsp_valid_ff && rsp_last_in) |-> state_ff == S_TK_FLSH)
      else $error("final update of a tick issued outside the flush step");

endmodule
